>>> design/mf3_pkg.sv
// Shared constants, types and helpers of the 3x3 max filter.
package mf3_pkg;

	// Default frame limits
	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 128;

	// Pixel and configuration port widths
	localparam int PIX_W   = 8;
	localparam int SIZE_W  = 8;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;

	// Register indexes (byte address 4*i)
	localparam logic [1:0] REG_ENABLE     = 2'd0;
	localparam logic [1:0] REG_FRAME_COLS = 2'd1;
	localparam logic [1:0] REG_FRAME_ROWS = 2'd2;

	// Reset values of the registers
	localparam logic              ENABLE_RST = 1'b1;
	localparam logic [SIZE_W-1:0] COLS_RST   = 8'd100;
	localparam logic [SIZE_W-1:0] ROWS_RST   = 8'd100;

	// Request kinds on the input stream
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Control carried with a request through the window stage
	typedef struct packed {
		logic is_pixel;  // request shifts the window
		logic emit;      // request produces an output pixel
		logic pass;      // disabled mode: output the input pixel
		logic border;    // output position lies on the frame border
		logic eof;       // last output pixel of the frame
	} s1_ctrl_t;

	// Larger of two pixels
	function automatic logic [PIX_W-1:0] max8(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

>>> design/mf3_line_store.sv
// Two line memories holding the previous two image rows.
module mf3_line_store #(
	parameter int MAX_COLS = mf3_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req,
	input  logic [$clog2(MAX_COLS)-1:0]   addr,
	input  logic [mf3_pkg::PIX_W-1:0]     pixel,
	output logic [mf3_pkg::PIX_W-1:0]     top,
	output logic [mf3_pkg::PIX_W-1:0]     mid
);
	import mf3_pkg::*;

	localparam int COL_W = $clog2(MAX_COLS);

	logic [PIX_W-1:0] mid_mem [MAX_COLS];
	logic [PIX_W-1:0] top_mem [MAX_COLS];
	logic [PIX_W-1:0] mid_rd_s1;
	logic [PIX_W-1:0] top_rd_s1;
	logic             wb_q;
	logic [COL_W-1:0] wb_addr_q;

	// Read the previous row and replace it with the new pixel (old data on read)
	always_ff @(posedge clk) begin
		if (req) begin
			mid_rd_s1     <= mid_mem[addr];
			mid_mem[addr] <= pixel;
		end
	end

	// Read the row before that; write back the moved-up row in the following cycle.
	// Consecutive requests never share a column, so the late write cannot
	// collide with the read of the following request.
	always_ff @(posedge clk) begin
		if (req) begin
			top_rd_s1 <= top_mem[addr];
		end
		if (wb_q) begin
			top_mem[wb_addr_q] <= mid_rd_s1;
		end
	end

	// Track the pending write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= 1'b0;
		end else begin
			wb_q <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			wb_addr_q <= addr;
		end
	end

	assign top = top_rd_s1;
	assign mid = mid_rd_s1;

endmodule

>>> design/max_filter_3x3_core.sv
// 3x3 max filter (grayscale dilation) over a raster pixel stream.
// Two register stages (window, output); the line memories do one read-modify-write per cycle.
// Throughput: one request per cycle while a full output register does not stall the input.
// A pixel's own output comes clamped frame_cols+1 pixel requests later; flush drains the rest.
// Reset loads the register defaults and clears valid flags, counters and window; line memory
// content stays undefined until written and needs no clearing pass.
module max_filter_3x3_core #(
	parameter int MAX_COLS = mf3_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = mf3_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	input  logic                          s_tuser,   // [0] cmd
	// Output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] value
	output logic                          m_tuser,   // [0] out_valid
	output logic                          m_tlast,   // end_of_frame
	// Configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mf3_pkg::APB_AW-1:0]    paddr,
	input  logic [mf3_pkg::APB_DW-1:0]    pwdata,
	output logic [mf3_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import mf3_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int FILL_W = $clog2(MAX_COLS + 2);

	// Configuration registers
	logic              enable_q;
	logic [SIZE_W-1:0] frame_cols_q;
	logic [SIZE_W-1:0] frame_rows_q;
	logic              cfg_wr;
	logic [1:0]        cfg_idx;

	// Positions and pending count
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [FILL_W-1:0] fill_q;

	// Frame size in use
	logic [CCNT_W-1:0] used_cols;
	logic [RCNT_W-1:0] used_rows;

	// Next positions
	logic [COL_W-1:0]  in_col_nx, out_col_nx;
	logic [ROW_W-1:0]  in_row_nx, out_row_nx;
	logic [COL_W:0]    in_col_inc, out_col_inc;
	logic [ROW_W:0]    in_row_inc, out_row_inc;

	// Request decode
	logic              acc;
	logic              is_pix;
	logic              flush_go;
	logic              win_emit;
	logic              out_border;
	logic              out_last;
	logic              in_last;
	s1_ctrl_t          ctrl_d;

	// Window stage
	logic              s1_valid_q;
	s1_ctrl_t          ctrl_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic              s1_adv;
	logic [PIX_W-1:0]  top_s1, mid_s1;
	logic [PIX_W-1:0]  cm0_q, cm1_q, cm2_q;
	logic [PIX_W-1:0]  col_max;
	logic [PIX_W-1:0]  win_max;
	logic [PIX_W-1:0]  value_s1;

	// Output register
	logic              m_valid_q;
	logic [PIX_W-1:0]  m_data_q;
	logic              m_user_q;
	logic              m_last_q;

	// Register access
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= ENABLE_RST;
			frame_cols_q <= COLS_RST;
			frame_rows_q <= ROWS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ENABLE:     enable_q     <= pwdata[0];
				REG_FRAME_COLS: frame_cols_q <= pwdata[SIZE_W-1:0];
				REG_FRAME_ROWS: frame_rows_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ENABLE:     prdata = {{(APB_DW-1){1'b0}}, enable_q};
			REG_FRAME_COLS: prdata = {{(APB_DW-SIZE_W){1'b0}}, frame_cols_q};
			REG_FRAME_ROWS: prdata = {{(APB_DW-SIZE_W){1'b0}}, frame_rows_q};
			default:        prdata = '0;
		endcase
	end

	// Clamp the frame size to the supported range
	always_comb begin
		priority if (frame_cols_q < 8'd3) begin
			used_cols = CCNT_W'(3);
		end else if (32'(frame_cols_q) > MAX_COLS) begin
			used_cols = CCNT_W'(MAX_COLS);
		end else begin
			used_cols = CCNT_W'(frame_cols_q);
		end
		priority if (frame_rows_q < 8'd3) begin
			used_rows = RCNT_W'(3);
		end else if (32'(frame_rows_q) > MAX_ROWS) begin
			used_rows = RCNT_W'(MAX_ROWS);
		end else begin
			used_rows = RCNT_W'(frame_rows_q);
		end
	end

	// Advance input and output positions in raster order
	always_comb begin
		in_col_inc  = {1'b0, in_col_q} + 1'b1;
		in_row_inc  = {1'b0, in_row_q} + 1'b1;
		out_col_inc = {1'b0, out_col_q} + 1'b1;
		out_row_inc = {1'b0, out_row_q} + 1'b1;

		in_col_nx = in_col_inc[COL_W-1:0];
		in_row_nx = in_row_q;
		if (32'(in_col_inc) >= 32'(used_cols)) begin
			in_col_nx = '0;
			in_row_nx = (32'(in_row_inc) >= 32'(used_rows)) ? '0 : in_row_inc[ROW_W-1:0];
		end

		out_col_nx = out_col_inc[COL_W-1:0];
		out_row_nx = out_row_q;
		if (32'(out_col_inc) >= 32'(used_cols)) begin
			out_col_nx = '0;
			out_row_nx = (32'(out_row_inc) >= 32'(used_rows)) ? '0 : out_row_inc[ROW_W-1:0];
		end
	end

	// Decode the request at the input
	assign s_tready = !s1_valid_q || s1_adv;
	assign acc      = s_tvalid && s_tready;
	assign is_pix   = (s_tuser == CMD_PIXEL);

	always_comb begin
		flush_go   = !is_pix && enable_q && (fill_q != '0) && (in_col_q == '0)
			&& (in_row_q == '0);
		win_emit   = is_pix && enable_q && (32'(fill_q) >= 32'(used_cols) + 1);
		out_border = (out_row_q == '0) || (32'(out_row_q) + 2 > 32'(used_rows))
			|| (out_col_q == '0) || (32'(out_col_q) + 2 > 32'(used_cols));
		out_last   = (32'(out_col_q) == 32'(used_cols) - 1)
			&& (32'(out_row_q) == 32'(used_rows) - 1);
		in_last    = (32'(in_col_q) == 32'(used_cols) - 1)
			&& (32'(in_row_q) == 32'(used_rows) - 1);

		ctrl_d.is_pixel = is_pix;
		ctrl_d.pass     = is_pix && !enable_q;
		ctrl_d.emit     = flush_go || win_emit || (is_pix && !enable_q);
		ctrl_d.border   = out_border;
		priority if (is_pix && !enable_q) begin
			ctrl_d.eof = in_last;
		end else if (flush_go || win_emit) begin
			ctrl_d.eof = out_last;
		end else begin
			ctrl_d.eof = 1'b0;
		end
	end

	// Update positions and the pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q    <= '0;
		end else if (acc) begin
			if (is_pix) begin
				in_col_q <= in_col_nx;
				in_row_q <= in_row_nx;
				if (!enable_q) begin
					// pass-through: drop pending outputs, follow the input
					fill_q    <= '0;
					out_col_q <= in_col_nx;
					out_row_q <= in_row_nx;
				end else if (win_emit) begin
					out_col_q <= out_col_nx;
					out_row_q <= out_row_nx;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (flush_go) begin
				out_col_q <= out_col_nx;
				out_row_q <= out_row_nx;
				fill_q    <= fill_q - 1'b1;
			end
		end
	end

	// Line memories, read at the input column
	mf3_line_store #(
		.MAX_COLS (MAX_COLS)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (acc && is_pix),
		.addr   (in_col_q),
		.pixel  (s_tdata),
		.top    (top_s1),
		.mid    (mid_s1)
	);

	// Window stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctrl_s1 <= ctrl_d;
			pix_s1  <= s_tdata;
		end
	end

	assign s1_adv = s1_valid_q && (!m_valid_q || m_tready);

	// Window kept as column maxima: the 3x3 maximum only needs those
	always_comb begin
		col_max = max8(max8(top_s1, mid_s1), pix_s1);
		if (ctrl_s1.is_pixel) begin
			win_max = max8(max8(cm1_q, cm2_q), col_max);
		end else begin
			win_max = max8(max8(cm0_q, cm1_q), cm2_q);
		end
		priority if (!ctrl_s1.emit) begin
			value_s1 = '0;
		end else if (ctrl_s1.pass) begin
			value_s1 = pix_s1;
		end else if (ctrl_s1.border) begin
			value_s1 = '0;
		end else begin
			value_s1 = win_max;
		end
	end

	// Shift the window left and bring in the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm0_q <= '0;
			cm1_q <= '0;
			cm2_q <= '0;
		end else if (s1_adv && ctrl_s1.is_pixel) begin
			cm0_q <= cm1_q;
			cm1_q <= cm2_q;
			cm2_q <= col_max;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_data_q <= value_s1;
			m_user_q <= ctrl_s1.emit;
			m_last_q <= ctrl_s1.emit && ctrl_s1.eof;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// Input stalls only when the window stage is blocked by a full output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid_q && m_tvalid && !m_tready)
		else $error("input stalled without a blocked output");

	// A result without a pixel carries zero value and no frame end
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
		else $error("empty result carries data");

	// Pass-through pixels drop any pending outputs
	a_pass_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_PIXEL) && !enable_q
		|=> fill_q == '0)
		else $error("pending count kept in pass-through mode");

endmodule
